### hw/rtl/sba_pkg.sv
// Shared constants, codes and handshake types of the sector bitmap allocator.
`default_nettype none
package sba_pkg;
	localparam int SECTOR_COUNT     = 4096;
	localparam int RESERVED_SECTORS = 16;
	localparam int WORD_BITS        = 64;
	localparam int WORD_COUNT       = (SECTOR_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIT_AW           = 6;
	localparam int CMD_W            = 2;
	localparam int SECTOR_W         = 12;
	localparam int BYTE_NUM_W       = 9;
	localparam int BYTE_W           = 8;
	localparam int LAST_BITS        = SECTOR_COUNT - WORD_BITS * (WORD_COUNT - 1);

	// Reserved sectors all sit in word zero; a shift by the full width wraps to all ones.
	localparam logic [WORD_BITS-1:0] RES_MASK  =
		(64'd1 << RESERVED_SECTORS) - 64'd1;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		(64'd1 << LAST_BITS) - 64'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_AP,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic init_wr;
		logic accept;
		logic scan;
		logic apply;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic init_last;
		logic scan_end;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/sba_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module sba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

### hw/rtl/sba_ctrl.sv
// Controller state machine of the sector bitmap allocator.
`default_nettype none
module sba_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [sba_pkg::CMD_W-1:0]  command,
	input  sba_pkg::dp_stat_t               stat,
	output sba_pkg::ctrl_cmd_t              cmd,
	output logic                            in_stall
);
	import sba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (command)
						CMD_ALLOC: state_d = ST_SCAN;
						CMD_MARK:  state_d = ST_RD;
						CMD_READ:  state_d = ST_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_AP;
			end
			ST_AP: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/sba_dp.sv
// Datapath of the sector bitmap allocator: bitmap RAM, scan address, search and result registers.
`default_nettype none
module sba_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  sba_pkg::ctrl_cmd_t                   cmd,
	output sba_pkg::dp_stat_t                    stat,
	input  wire logic [sba_pkg::CMD_W-1:0]       command,
	input  wire logic [sba_pkg::SECTOR_W-1:0]    target_sector,
	input  wire logic [sba_pkg::BYTE_NUM_W-1:0]  byte_number,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 status,
	output logic      [sba_pkg::SECTOR_W-1:0]    sector_number,
	output logic      [sba_pkg::BYTE_W-1:0]      bitmap_byte
);
	import sba_pkg::*;

	logic [WORD_AW-1:0]    addr_q;
	logic [WORD_AW-1:0]    chk_q;
	logic                  dv_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [BIT_AW-1:0]     sel_q;
	logic                  inrange_q;
	logic                  res_status_q;
	logic [SECTOR_W-1:0]   res_sector_q;
	logic [BYTE_W-1:0]     res_byte_q;
	logic                  out_valid_q;

	logic                  wr_en;
	logic [WORD_AW-1:0]    wr_addr;
	logic [WORD_BITS-1:0]  wr_data;
	logic [WORD_BITS-1:0]  rd_data;

	logic [WORD_BITS-1:0]  vmask;
	logic [WORD_BITS-1:0]  scan_word;
	logic [WORD_BITS-1:0]  read_word;
	logic [WORD_BITS-1:0]  shifted;
	logic [WORD_BITS-1:0]  onehot;
	logic                  found;
	logic                  last_word;
	logic [BIT_AW-1:0]     bit_idx;
	logic [WORD_AW+BIT_AW-1:0] sec_full;
	logic [BYTE_W-1:0]     packed_byte;

	sba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// Sectors past the end of a partial last word count as used for search, zero for reads.
	always_comb begin
		last_word = (chk_q == WORD_AW'(WORD_COUNT - 1));
		vmask     = last_word ? LAST_MASK : '1;
		scan_word = rd_data | ~vmask;
		read_word = rd_data & vmask;
		onehot    = ~scan_word & (scan_word + 64'd1);
		found     = |(~scan_word);
		bit_idx   = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (onehot[i]) begin
				bit_idx = bit_idx | BIT_AW'(i);
			end
		end
		sec_full = {chk_q, bit_idx};
		shifted  = read_word >> sel_q;
		for (int j = 0; j < BYTE_W; j++) begin
			packed_byte[BYTE_W-1-j] = shifted[j];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_q;
		wr_data = rd_data | onehot;
		if (cmd.init_wr) begin
			wr_en   = 1'b1;
			wr_addr = addr_q;
			wr_data = (addr_q == '0) ? RES_MASK : '0;
		end else if (cmd.scan) begin
			wr_en = dv_q && found;
		end else if (cmd.apply) begin
			wr_en   = (cmd_q == CMD_MARK) && inrange_q;
			wr_data = rd_data | (64'd1 << sel_q);
		end
	end

	assign stat.init_last = (addr_q == WORD_AW'(WORD_COUNT - 1));
	assign stat.scan_end  = dv_q && (found || last_word);
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			dv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr || cmd.scan) begin
				addr_q <= addr_q + WORD_AW'(1);
			end else if (cmd.accept) begin
				case (command)
					CMD_MARK: addr_q <= WORD_AW'(target_sector >> BIT_AW);
					CMD_READ: addr_q <= WORD_AW'(byte_number >> 3);
					default:  addr_q <= '0;
				endcase
			end
			if (cmd.accept) begin
				dv_q <= 1'b0;
			end else if (cmd.scan) begin
				dv_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_q <= addr_q;
		if (cmd.accept) begin
			cmd_q        <= command;
			res_status_q <= 1'b0;
			res_sector_q <= '0;
			res_byte_q   <= '0;
			case (command)
				CMD_MARK: begin
					sel_q     <= target_sector[BIT_AW-1:0];
					inrange_q <= (32'(target_sector) < SECTOR_COUNT);
				end
				CMD_READ: begin
					sel_q     <= {byte_number[2:0], 3'b000};
					inrange_q <= (32'(byte_number >> 3) < WORD_COUNT);
				end
				default: begin
					sel_q     <= '0;
					inrange_q <= 1'b0;
				end
			endcase
		end
		if (cmd.scan && dv_q) begin
			if (found) begin
				res_sector_q <= SECTOR_W'(sec_full);
			end else if (last_word) begin
				res_status_q <= 1'b1;
			end
		end
		if (cmd.apply && (cmd_q == CMD_READ) && inrange_q) begin
			res_byte_q <= packed_byte;
		end
		if (cmd.load_out) begin
			status        <= res_status_q;
			sector_number <= res_sector_q;
			bitmap_byte   <= res_byte_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

### hw/rtl/sector_bitmap_allocator.sv
// Top level of the sector bitmap allocator: controller plus datapath.
// One item at a time: the next item is taken once the result is in the output register.
// Mark and read byte read the bitmap word, then mark the sector or extract the byte.
// Allocate scans the 64-bit words in order until a free sector or the last word is found,
// so it scans at most WORD_COUNT (64) words before its result is offered.
// Reset: a clearing pass writes all WORD_COUNT (64) words of the bitmap, reserved sectors set.
`default_nettype none
module sector_bitmap_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [sba_pkg::CMD_W-1:0]       command,
	input  wire logic [sba_pkg::SECTOR_W-1:0]    target_sector,
	input  wire logic [sba_pkg::BYTE_NUM_W-1:0]  byte_number,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 status,
	output logic      [sba_pkg::SECTOR_W-1:0]    sector_number,
	output logic      [sba_pkg::BYTE_W-1:0]      bitmap_byte
);
	import sba_pkg::*;

	// The controller sequences each item; the datapath holds the bitmap and the result.
	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	// The controller accepts an item only when idle, after the clearing pass has finished.
	sba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd),
		.in_stall (in_stall)
	);

	// The datapath keeps a registered output stage, so a finished result may wait for the
	// consumer while the next item is accepted and processed.
	sba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctrl_cmd),
		.stat          (dp_stat),
		.command       (command),
		.target_sector (target_sector),
		.byte_number   (byte_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.sector_number (sector_number),
		.bitmap_byte   (bitmap_byte)
	);
endmodule
`default_nettype wire
